[rtl/fcom_pkg.sv]
`timescale 1ns / 1ps
package fcom_pkg;

	// quarter-wave sine polynomial, Q16
	localparam logic [16:0] SIN_A   = 17'd102944;
	localparam logic [16:0] SIN_B   = 17'd42048;
	localparam logic [16:0] SIN_C   = 17'd4640;
	localparam logic [16:0] QUARTER = 17'd65536;

	// quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	localparam int TRIG_LAT = 6;
	localparam int LANES    = 4;

endpackage

[rtl/fcom_trig.sv]
`timescale 1ns / 1ps
module fcom_trig import fcom_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [15:0]        heading,
	output logic               out_v,
	output logic signed [16:0] sn,
	output logic signed [16:0] cs
);
	localparam int AB = ANGLE_BITS;

	logic [31:0]   hx;
	logic [AB-1:0] ang;
	logic [AB+13:0] zx;
	logic [16:0]   z_in;

	logic [6:1] v_s;
	logic [1:0] q_s1, q_s2, q_s3, q_s4, q_s5;
	logic [16:0] za_s1, zb_s1, za_s2, zb_s2, za_s3, zb_s3, za_s4, zb_s4;
	logic [16:0] z2a_s2, z2b_s2, z2a_s3, z2b_s3;
	logic [15:0] ina_s3, inb_s3;
	logic [16:0] oa_s4, ob_s4;
	logic [16:0] sa_s5, sb_s5;
	logic signed [16:0] sn_s6, cs_s6;

	logic [33:0] pa2, pb2, pa3, pb3, pa4, pb4, pa5, pb5;
	logic signed [16:0] sa_p, sa_n, sb_p, sb_n;

	assign hx   = {16'd0, heading};
	assign ang  = hx[AB-1:0];
	assign zx   = {ang[AB-3:0], 16'd0};
	assign z_in = {1'b0, zx[AB+13 -: 16]};

	assign pa2 = 34'(za_s1) * 34'(za_s1);
	assign pb2 = 34'(zb_s1) * 34'(zb_s1);
	assign pa3 = 34'(SIN_C) * 34'(z2a_s2);
	assign pb3 = 34'(SIN_C) * 34'(z2b_s2);
	assign pa4 = 34'(ina_s3) * 34'(z2a_s3);
	assign pb4 = 34'(inb_s3) * 34'(z2b_s3);
	assign pa5 = 34'(oa_s4) * 34'(za_s4);
	assign pb5 = 34'(ob_s4) * 34'(zb_s4);

	assign sa_p = $signed(sa_s5);
	assign sb_p = $signed(sb_s5);
	assign sa_n = $signed(17'd0 - sa_s5);
	assign sb_n = $signed(17'd0 - sb_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[5:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1  <= ang[AB-1:AB-2];
			za_s1 <= z_in;
			zb_s1 <= QUARTER - z_in;

			q_s2   <= q_s1;
			za_s2  <= za_s1;
			zb_s2  <= zb_s1;
			z2a_s2 <= pa2[32:16];
			z2b_s2 <= pb2[32:16];

			q_s3   <= q_s2;
			za_s3  <= za_s2;
			zb_s3  <= zb_s2;
			z2a_s3 <= z2a_s2;
			z2b_s3 <= z2b_s2;
			ina_s3 <= SIN_B[15:0] - pa3[31:16];
			inb_s3 <= SIN_B[15:0] - pb3[31:16];

			q_s4  <= q_s3;
			za_s4 <= za_s3;
			zb_s4 <= zb_s3;
			oa_s4 <= SIN_A - pa4[32:16];
			ob_s4 <= SIN_A - pb4[32:16];

			q_s5  <= q_s4;
			sa_s5 <= pa5[33:17];
			sb_s5 <= pb5[33:17];

			case (q_s5)
				QUAD_0: begin
					sn_s6 <= sa_p;
					cs_s6 <= sb_p;
				end
				QUAD_1: begin
					sn_s6 <= sb_p;
					cs_s6 <= sa_n;
				end
				QUAD_2: begin
					sn_s6 <= sa_n;
					cs_s6 <= sb_n;
				end
				default: begin
					sn_s6 <= sb_n;
					cs_s6 <= sa_p;
				end
			endcase
		end
	end

	assign out_v = v_s[6];
	assign sn    = sn_s6;
	assign cs    = cs_s6;

endmodule

[rtl/fcom_mix.sv]
`timescale 1ns / 1ps
module fcom_mix #(
	parameter int FRACTION_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_v,
	input  logic signed [FRACTION_BITS+1:0] x,
	input  logic signed [FRACTION_BITS+1:0] y,
	input  logic signed [FRACTION_BITS+1:0] w,
	input  logic signed [16:0]             sn,
	input  logic signed [16:0]             cs,
	output logic                           out_v,
	output logic [FRACTION_BITS+17:0]      denom,
	output logic [3:0]                     neg,
	output logic [3:0][FRACTION_BITS+17:0] mag
);
	localparam int FB = FRACTION_BITS;
	localparam int DW = FB + 18;
	localparam int PW = FB + 19;
	localparam int SW = FB + 20;
	localparam logic [DW-1:0] ONE = DW'(1) << (FB + 15);

	logic [4:1] v_s;
	logic signed [PW-1:0] pxc_s1, pys_s1, pyc_s1, pxs_s1, ww_s1;
	logic signed [SW-1:0] vx_s2, vy_s2, w_s2;
	logic [DW-1:0] ax_s3, ay_s3, aw_s3;
	logic signed [SW-1:0] sum_s3 [4];
	logic [DW-1:0] den_s4;
	logic [3:0] neg_s4;
	logic [3:0][DW-1:0] mag_s4;

	logic [SW-1:0] abx, aby, abw;
	logic [DW-1:0] tot;
	logic [SW-1:0] abs_sum [4];

	assign abx = vx_s2[SW-1] ? SW'(-vx_s2) : SW'(vx_s2);
	assign aby = vy_s2[SW-1] ? SW'(-vy_s2) : SW'(vy_s2);
	assign abw = w_s2[SW-1]  ? SW'(-w_s2)  : SW'(w_s2);
	assign tot = ax_s3 + ay_s3 + aw_s3;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			abs_sum[k] = sum_s3[k][SW-1] ? SW'(-sum_s3[k]) : SW'(sum_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[3:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s1 <= x * cs;
			pys_s1 <= y * sn;
			pyc_s1 <= y * cs;
			pxs_s1 <= x * sn;
			ww_s1  <= $signed({{2{w[FB+1]}}, w, 15'd0});

			vx_s2 <= pxc_s1 + pys_s1;
			vy_s2 <= pyc_s1 - pxs_s1;
			w_s2  <= SW'(ww_s1);

			ax_s3     <= abx[DW-1:0];
			ay_s3     <= aby[DW-1:0];
			aw_s3     <= abw[DW-1:0];
			sum_s3[0] <= vy_s2 + vx_s2 + w_s2;
			sum_s3[1] <= vy_s2 - vx_s2 + w_s2;
			sum_s3[2] <= vy_s2 - vx_s2 - w_s2;
			sum_s3[3] <= vy_s2 + vx_s2 - w_s2;

			// small demand passes through unscaled
			den_s4 <= (tot < ONE) ? ONE : tot;
			for (int k = 0; k < 4; k++) begin
				neg_s4[k] <= sum_s3[k][SW-1];
				mag_s4[k] <= abs_sum[k][DW-1:0];
			end
		end
	end

	assign out_v = v_s[4];
	assign denom = den_s4;
	assign neg   = neg_s4;
	assign mag   = mag_s4;

endmodule

[rtl/fcom_div.sv]
`timescale 1ns / 1ps
module fcom_div import fcom_pkg::*; #(
	parameter int FRACTION_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  logic [FRACTION_BITS+17:0]           denom,
	input  logic [LANES-1:0]                    neg,
	input  logic [LANES-1:0][FRACTION_BITS+17:0] mag,
	output logic                                out_v,
	output logic [LANES-1:0]                    out_neg,
	output logic [LANES-1:0][FRACTION_BITS:0]   quo
);
	localparam int FB = FRACTION_BITS;
	localparam int DW = FB + 18;
	localparam int QB = FB + 1;
	localparam int CW = DW + QB + 1;

	logic [QB:0]                   v_s;
	logic [CW-1:0]                 d2_s  [QB];
	logic [LANES-1:0][CW-1:0]      r_s   [QB];
	logic [LANES-1:0][QB-1:0]      q_s   [QB+1];
	logic [LANES-1:0]              neg_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QB-1:0], in_v};
		end
	end

	// rounding: (mag * 2^(FB+1) + d) / (2d)
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[0]  <= CW'({denom, 1'b0});
			neg_s[0] <= neg;
			for (int l = 0; l < LANES; l++) begin
				r_s[0][l] <= CW'({mag[l], {QB{1'b0}}}) + CW'(denom);
				q_s[0][l] <= '0;
			end
		end
	end

	for (genvar g = 0; g < QB; g++) begin : g_bit
		localparam int SH = QB - 1 - g;
		logic [CW-1:0]    sub;
		logic [LANES-1:0] ge;

		assign sub = d2_s[g] << SH;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				ge[l] = r_s[g][l] >= sub;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[g+1] <= neg_s[g];
				for (int l = 0; l < LANES; l++) begin
					q_s[g+1][l] <= {q_s[g][l][QB-2:0], ge[l]};
				end
			end
		end

		if (g < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					d2_s[g+1] <= d2_s[g];
					for (int l = 0; l < LANES; l++) begin
						r_s[g+1][l] <= ge[l] ? (r_s[g][l] - sub) : r_s[g][l];
					end
				end
			end
		end
	end

	assign out_v   = v_s[QB];
	assign out_neg = neg_s[QB];
	assign quo     = q_s[QB];

endmodule

[rtl/field_centric_omni_wheel_mixer_unit.sv]
`timescale 1ns / 1ps
// Field-centric X-drive wheel mixer.
// Command channel (cmd_valid / cmd_stall) takes one transaction of three
// Q1.10 stick axes and a binary-angle heading. Result channel (res_valid /
// res_stall) returns the four wheel commands of that transaction together.
// Each axis is clamped to +-1, the translation is rotated by minus the
// heading, the four wheel sums are formed and each is scaled by
// 1 / max(1, |vx|+|vy|+|w|), rounded to nearest with ties away from zero.
// The pipeline is the clamp register, the pipelined polynomial sine/cosine
// (6 stages), the rotate and sum stages (4), the restoring divider, one
// quotient bit per stage, and the output register.
// Throughput: one transaction per cycle unless the pipeline is held; no dependence between items.
// Reset clears only the valid bits; the data registers are not reset.
// When res_stall is high with a result pending, the whole pipeline holds
// and cmd_stall rises; nothing is dropped or repeated.
module field_centric_omni_wheel_mixer_unit import fcom_pkg::*; #(
	parameter int FRACTION_BITS = 10,
	parameter int ANGLE_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic signed [FRACTION_BITS+1:0] stick_x,
	input  logic signed [FRACTION_BITS+1:0] stick_y,
	input  logic signed [FRACTION_BITS+1:0] stick_turn,
	input  logic [15:0]                     heading,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic signed [FRACTION_BITS+1:0] left_front,
	output logic signed [FRACTION_BITS+1:0] left_back,
	output logic signed [FRACTION_BITS+1:0] right_front,
	output logic signed [FRACTION_BITS+1:0] right_back
);
	localparam int FB = FRACTION_BITS;
	localparam int AW = FB + 2;
	localparam int DW = FB + 18;
	localparam logic signed [AW-1:0] AX_MAX = $signed(AW'(1) << FB);
	localparam logic signed [AW-1:0] AX_MIN = -AX_MAX;

	logic en;

	// stage 1: clamp
	logic                 v_s1;
	logic signed [AW-1:0] x_s1, y_s1, w_s1;
	logic [15:0]          hd_s1;
	logic signed [AW-1:0] x_c, y_c, w_c;

	// axis delay to line up with the sine/cosine
	logic signed [AW-1:0] xd_q [TRIG_LAT];
	logic signed [AW-1:0] yd_q [TRIG_LAT];
	logic signed [AW-1:0] wd_q [TRIG_LAT];

	logic               trig_v;
	logic signed [16:0] sn, cs;

	logic                       mix_v;
	logic [DW-1:0]              denom;
	logic [LANES-1:0]           neg;
	logic [LANES-1:0][DW-1:0]   mag;

	logic                       div_v;
	logic [LANES-1:0]           div_neg;
	logic [LANES-1:0][FB:0]     quo;

	logic                       res_v_q;
	logic signed [AW-1:0]       res_q [LANES];

	// whole pipeline advances unless a finished result is held
	assign en        = !(res_v_q && res_stall);
	assign cmd_stall = !en;

	always_comb begin
		x_c = (stick_x > AX_MAX) ? AX_MAX : ((stick_x < AX_MIN) ? AX_MIN : stick_x);
		y_c = (stick_y > AX_MAX) ? AX_MAX : ((stick_y < AX_MIN) ? AX_MIN : stick_y);
		w_c = (stick_turn > AX_MAX) ? AX_MAX :
			((stick_turn < AX_MIN) ? AX_MIN : stick_turn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= cmd_valid;
			res_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_c;
			y_s1  <= y_c;
			w_s1  <= w_c;
			hd_s1 <= heading;
			xd_q[0] <= x_s1;
			yd_q[0] <= y_s1;
			wd_q[0] <= w_s1;
			for (int k = 1; k < TRIG_LAT; k++) begin
				xd_q[k] <= xd_q[k-1];
				yd_q[k] <= yd_q[k-1];
				wd_q[k] <= wd_q[k-1];
			end
			for (int l = 0; l < LANES; l++) begin
				res_q[l] <= div_neg[l] ? $signed(AW'(0) - AW'(quo[l])) : $signed(AW'(quo[l]));
			end
		end
	end

	fcom_trig #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s1),
		.heading(hd_s1),
		.out_v  (trig_v),
		.sn     (sn),
		.cs     (cs)
	);

	fcom_mix #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mix (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_v  (trig_v),
		.x     (xd_q[TRIG_LAT-1]),
		.y     (yd_q[TRIG_LAT-1]),
		.w     (wd_q[TRIG_LAT-1]),
		.sn    (sn),
		.cs    (cs),
		.out_v (mix_v),
		.denom (denom),
		.neg   (neg),
		.mag   (mag)
	);

	fcom_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (mix_v),
		.denom  (denom),
		.neg    (neg),
		.mag    (mag),
		.out_v  (div_v),
		.out_neg(div_neg),
		.quo    (quo)
	);

	assign res_valid   = res_v_q;
	assign left_front  = res_q[0];
	assign left_back   = res_q[1];
	assign right_front = res_q[2];
	assign right_back  = res_q[3];

`ifndef SYNTH
	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (left_front <= AX_MAX) && (left_front >= AX_MIN))
		else $error("left_front out of range");

	a_rb_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (right_back <= AX_MAX) && (right_back >= AX_MIN))
		else $error("right_back out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(mix_v) && $stable(div_v))
		else $error("pipeline moved while held");
`endif

endmodule

[tb/sv/wheel_mix_checker.sv]
`timescale 1ns / 1ps
module wheel_mix_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic signed [11:0] stick_x,
	input  logic signed [11:0] stick_y,
	input  logic signed [11:0] stick_turn,
	input  logic [15:0]        heading,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic signed [11:0] left_front,
	input  logic signed [11:0] left_back,
	input  logic signed [11:0] right_front,
	input  logic signed [11:0] right_back,
	output int                 fail_count,
	output int                 pending
);
	import fcom_pkg::*;

	typedef struct packed {
		logic signed [11:0] lf;
		logic signed [11:0] lb;
		logic signed [11:0] rf;
		logic signed [11:0] rb;
	} wheel_cmd_t;

	wheel_cmd_t wheel_q[$];

	function automatic longint clamp_axis(logic signed [11:0] v);
		if (v > 12'sd1024) begin
			return 1024;
		end
		if (v < -12'sd1024) begin
			return -1024;
		end
		return longint'(v);
	endfunction

	function automatic longint poly_sine(longint unsigned z);
		longint unsigned z2, inner, outer;
		z2 = (z * z) >> 16;
		inner = SIN_B - ((SIN_C * z2) >> 16);
		outer = SIN_A - ((inner * z2) >> 16);
		return longint'((outer * z) >> 17);
	endfunction

	function automatic logic signed [11:0] round_div(longint n, longint d);
		longint unsigned mag, q;
		mag = longint'(n < 0 ? -n : n) << 10;
		q = (mag * 2 + d) / (2 * d);
		return n < 0 ? 12'(-longint'(q)) : 12'(q);
	endfunction

	function automatic wheel_cmd_t mix_wheels(logic signed [11:0] sx, logic signed [11:0] sy,
			logic signed [11:0] st, logic [15:0] hd);
		longint x, y, w, sz, cz, sn, cs, vx, vy, den;
		logic [1:0] quad;
		longint unsigned z;
		wheel_cmd_t r;
		x = clamp_axis(sx);
		y = clamp_axis(sy);
		w = clamp_axis(st) * 32768;
		quad = hd[15:14];
		z = longint'(hd[13:0]) << 2;
		sz = poly_sine(z);
		cz = poly_sine(QUARTER - z);
		case (quad)
			QUAD_0: begin sn = sz; cs = cz; end
			QUAD_1: begin sn = cz; cs = -sz; end
			QUAD_2: begin sn = -sz; cs = -cz; end
			default: begin sn = -cz; cs = sz; end
		endcase
		vx = x * cs + y * sn;
		vy = y * cs - x * sn;
		den = (vx < 0 ? -vx : vx) + (vy < 0 ? -vy : vy) + (w < 0 ? -w : w);
		if (den < (longint'(1) << 25)) begin
			den = longint'(1) << 25;
		end
		r.lf = round_div(vy + vx + w, den);
		r.lb = round_div(vy - vx + w, den);
		r.rf = round_div(vy - vx - w, den);
		r.rb = round_div(vy + vx - w, den);
		return r;
	endfunction

	assign pending = wheel_q.size();

	always @(posedge clk or negedge arst_n) begin
		wheel_cmd_t e;
		if (!arst_n) begin
			fail_count <= 0;
			wheel_q.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (wheel_q.size() == 0) begin
					$error("unexpected result transaction");
					fail_count <= fail_count + 1;
				end else begin
					e = wheel_q.pop_front();
					if (e.lf !== left_front) $error("left_front exp %0d got %0d", e.lf, left_front);
					if (e.lb !== left_back) $error("left_back exp %0d got %0d", e.lb, left_back);
					if (e.rf !== right_front)
						$error("right_front exp %0d got %0d", e.rf, right_front);
					if (e.rb !== right_back) $error("right_back exp %0d got %0d", e.rb, right_back);
					if (e.lf !== left_front || e.lb !== left_back || e.rf !== right_front
							|| e.rb !== right_back) begin
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				wheel_q.push_back(mix_wheels(stick_x, stick_y, stick_turn, heading));
			end
		end
	end
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic signed [11:0] stick_x = '0;
	logic signed [11:0] stick_y = '0;
	logic signed [11:0] stick_turn = '0;
	logic [15:0] heading = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [11:0] left_front, left_back, right_front, right_back;
	int fail_count, pending;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit stim_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	field_centric_omni_wheel_mixer_unit DUT (.*);

	wheel_mix_checker u_checker (.*);

	// receiver: own stall pattern, plus long hold-offs so the pipe backs up
	initial begin
		int mode;
		int hold;
		mode = 0;
		hold = 0;
		while (1) begin
			@(negedge clk);
			if (long_hold) begin
				res_stall <= 1'b1;
				repeat (80) @(negedge clk);
				long_hold = 1'b0;
			end
			if (hold == 0) begin
				mode = $urandom_range(0, 3);
				hold = $urandom_range(1, 40);
			end
			hold--;
			case (mode)
				0: res_stall <= 1'b0;                        // free run
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: res_stall <= ($urandom_range(0, 1) == 0);
				default: res_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > 2000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one transaction and hold it until the handshake completes.
	task automatic send_cmd(logic signed [11:0] sx, logic signed [11:0] sy,
			logic signed [11:0] st, logic [15:0] hd);
		cmd_valid <= 1'b1;
		stick_x <= sx;
		stick_y <= sy;
		stick_turn <= st;
		heading <= hd;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	task automatic rest();
		cmd_valid <= 1'b0;
	endtask

	function automatic logic signed [11:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 12'($urandom_range(0, 4095));          // full range, saturates
			1: return $urandom_range(0, 1) ? 12'sd1024 : -12'sd1024;
			2: return 12'sd0;
			3: return 12'($urandom_range(0, 40)) - 12'sd20;   // small demand
			default: return 12'($urandom_range(0, 2048)) - 12'sd1024;
		endcase
	endfunction

	function automatic logic [15:0] rand_heading();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 3)) << 14;        // quadrant edges
			1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4))
				- 16'd2;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic signed [11:0] ax[6];
		logic [15:0] hd[8];
		int burst;
		ax = '{-12'sd2048, 12'sd2047, -12'sd1024, 12'sd1024, 12'sd0, 12'sd1};
		hd = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000, 16'h0001, 16'h5555};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: all zero, extremes, saturation, quadrant edges, ties region
		send_cmd(0, 0, 0, 0);
		for (int i = 0; i < 6; i++) begin
			send_cmd(ax[i], ax[5 - i], ax[(i + 2) % 6], hd[i]);
		end
		for (int i = 0; i < 8; i++) begin
			send_cmd(12'sd1024, 12'sd0, 12'sd0, hd[i]);
		end
		send_cmd(12'sd3, -12'sd5, 12'sd7, 16'h1234);
		send_cmd(12'sd0, 12'sd0, 12'sd2047, 16'hABCD);
		send_cmd(-12'sd1, 12'sd1, -12'sd1, 16'hFFFF);
		rest();

		// pause until everything has drained
		while (pending != 0) @(negedge clk);

		// random: bursts and gaps; long receiver hold-offs midway
		for (int n = 0; n < 1100; ) begin
			burst = $urandom_range(1, 30);
			if (n >= 400 && n < 430) long_hold = 1'b1;
			for (int b = 0; b < burst; b++, n++) begin
				send_cmd(rand_axis(), rand_axis(), rand_axis(), rand_heading());
			end
			if ($urandom_range(0, 2) == 0) begin
				rest();
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		rest();

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
